// ===== hdl/utv_pkg.sv =====
`timescale 1ns / 1ps

package utv_pkg;

   // decoder state carried from one byte to the next
   typedef struct packed {
      logic [1:0]  pending_count;
      logic [20:0] code_accum;
      logic [1:0]  seq_class;
      logic        error_seen;
   } state_type;

   // bytes that are never allowed
   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_NEWLINE = 8'h0a;

   // lead byte ranges
   localparam logic [7:0] LEAD_ASCII_END = 8'h80;
   localparam logic [7:0] LEAD2_LO       = 8'hc2;
   localparam logic [7:0] LEAD2_HI       = 8'hdf;
   localparam logic [7:0] LEAD3_LO       = 8'he0;
   localparam logic [7:0] LEAD3_HI       = 8'hef;
   localparam logic [7:0] LEAD4_LO       = 8'hf0;
   localparam logic [7:0] LEAD4_HI       = 8'hf4;

   // continuation byte form 10xxxxxx
   localparam logic [1:0] CONT_TAG = 2'b10;

   // sequence classes
   localparam logic [1:0] CLASS_NONE = 2'd0;
   localparam logic [1:0] CLASS_TWO  = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR = 2'd3;

   // code point limits
   localparam logic [20:0] MIN_TWO       = 21'h000080;
   localparam logic [20:0] MIN_THREE     = 21'h000800;
   localparam logic [20:0] MIN_FOUR      = 21'h010000;
   localparam logic [20:0] CODE_MAX      = 21'h10ffff;
   localparam logic [20:0] SURROGATE_LO  = 21'h00d800;
   localparam logic [20:0] SURROGATE_HI  = 21'h00dfff;

endpackage

// ===== hdl/utv_step.sv =====
`timescale 1ns / 1ps

module utv_step (
   input  utv_pkg::state_type cur_state,
   input  logic [7:0]         byte_in,
   input  logic               is_last,
   output utv_pkg::state_type nxt_state,
   output logic               verdict
);

   utv_pkg::state_type upd;
   logic [20:0]        accum_shift;
   logic [20:0]        class_min;
   logic [1:0]         pend_dec;

   // continuation byte appended to the gathered code point
   assign accum_shift = {cur_state.code_accum[14:0], byte_in[5:0]};
   assign pend_dec    = cur_state.pending_count - 2'd1;

   // smallest legal value for the current sequence length
   always_comb begin
      case (cur_state.seq_class)
         utv_pkg::CLASS_THREE: class_min = utv_pkg::MIN_THREE;
         utv_pkg::CLASS_FOUR:  class_min = utv_pkg::MIN_FOUR;
         default:              class_min = utv_pkg::MIN_TWO;
      endcase
   end

   // decode one byte
   always_comb begin
      upd = cur_state;
      if (cur_state.pending_count == 2'd0) begin
         // lead position
         if (byte_in == utv_pkg::BYTE_NUL || byte_in == utv_pkg::BYTE_NEWLINE) begin
            upd.error_seen = 1'b1;
         end else if (byte_in < utv_pkg::LEAD_ASCII_END) begin
            upd.error_seen = cur_state.error_seen;
         end else if (byte_in >= utv_pkg::LEAD2_LO && byte_in <= utv_pkg::LEAD2_HI) begin
            upd.pending_count = 2'd1;
            upd.code_accum    = {16'd0, byte_in[4:0]};
            upd.seq_class     = utv_pkg::CLASS_TWO;
         end else if (byte_in >= utv_pkg::LEAD3_LO && byte_in <= utv_pkg::LEAD3_HI) begin
            upd.pending_count = 2'd2;
            upd.code_accum    = {17'd0, byte_in[3:0]};
            upd.seq_class     = utv_pkg::CLASS_THREE;
         end else if (byte_in >= utv_pkg::LEAD4_LO && byte_in <= utv_pkg::LEAD4_HI) begin
            upd.pending_count = 2'd3;
            upd.code_accum    = {18'd0, byte_in[2:0]};
            upd.seq_class     = utv_pkg::CLASS_FOUR;
         end else begin
            upd.error_seen = 1'b1;
         end
      end else if (byte_in[7:6] != utv_pkg::CONT_TAG) begin
         // malformed continuation drops the sequence
         upd.error_seen    = 1'b1;
         upd.pending_count = 2'd0;
      end else begin
         upd.code_accum    = accum_shift;
         upd.pending_count = pend_dec;
         // range checks on a completed sequence
         if (pend_dec == 2'd0) begin
            if (accum_shift < class_min || accum_shift > utv_pkg::CODE_MAX ||
                (accum_shift >= utv_pkg::SURROGATE_LO &&
                 accum_shift <= utv_pkg::SURROGATE_HI)) begin
               upd.error_seen = 1'b1;
            end
         end
      end
   end

   // verdict and clear on the final byte
   assign verdict   = !upd.error_seen && (upd.pending_count == 2'd0);
   assign nxt_state = is_last ? '0 : upd;

endmodule

// ===== hdl/utf8_tag_validator.sv =====
`timescale 1ns / 1ps
// the verdict is registered as its final byte leaves the input register
// throughput: one byte per cycle, set by the combinational decode between the
// input register and the result register; a final byte waits only while an
// earlier verdict is still held at the output
// reset: synchronous, active high; clears the decoder state and both valid flags

module utf8_tag_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_valid
);

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_byte_ff;
   logic               s1_last_ff;
   logic               s1_advance;
   utv_pkg::state_type state_ff, state_in;
   logic               verdict;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_is_valid_ff;

   // per-byte decode
   utv_step u_step (
      .cur_state (state_ff),
      .byte_in   (s1_byte_ff),
      .is_last   (s1_last_ff),
      .nxt_state (state_in),
      .verdict   (verdict)
   );

   // an item leaves the input register unless it is a final byte meeting a held verdict
   assign s1_advance  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_valid || (s1_valid_ff && !s1_advance);

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_byte_in;
         s1_last_ff <= req_is_last;
      end
      if (s1_advance && s1_last_ff) begin
         rsp_is_valid_ff <= verdict;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

   // state is cleared after every final byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> state_ff == '0)
      else $error("decoder state not cleared after final byte");

   // outstanding continuations never exceed the sequence class
   a_pending_class: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_count <= state_ff.seq_class)
      else $error("pending count above sequence class");

   // a verdict only appears after a final byte was decoded
   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("verdict without final byte");

   // input stalls only while a final byte in the input register meets a held verdict
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff)
      else $error("input stalled without cause");

endmodule

// ===== tb/utf8_verdict_checker.sv =====
`timescale 1ns / 1ps

module utf8_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       req_is_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_is_valid,
   output int         mismatch_count,
   output int         verdicts_owed,
   output int         verdicts_seen,
   output int         valid_seen
);

   // running decode of the string in flight
   utv_pkg::state_type decoder = '0;
   logic               expected_verdicts[$];
   logic               want;

   task automatic report_mismatch(input string what);
      $display("%0t ns  verdict mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // advance the decode by one byte
   function automatic utv_pkg::state_type decode_byte(input utv_pkg::state_type s,
                                                      input logic [7:0] b);
      utv_pkg::state_type n;
      logic [20:0]        floor_cp;
      n = s;
      if (s.pending_count == 2'd0) begin
         // lead position
         if (b == utv_pkg::BYTE_NUL || b == utv_pkg::BYTE_NEWLINE) begin
            n.error_seen = 1'b1;
         end else if (b >= utv_pkg::LEAD_ASCII_END) begin
            if (b >= utv_pkg::LEAD2_LO && b <= utv_pkg::LEAD2_HI) begin
               n.pending_count = 2'd1;
               n.code_accum    = {16'd0, b[4:0]};
               n.seq_class     = utv_pkg::CLASS_TWO;
            end else if (b >= utv_pkg::LEAD3_LO && b <= utv_pkg::LEAD3_HI) begin
               n.pending_count = 2'd2;
               n.code_accum    = {17'd0, b[3:0]};
               n.seq_class     = utv_pkg::CLASS_THREE;
            end else if (b >= utv_pkg::LEAD4_LO && b <= utv_pkg::LEAD4_HI) begin
               n.pending_count = 2'd3;
               n.code_accum    = {18'd0, b[2:0]};
               n.seq_class     = utv_pkg::CLASS_FOUR;
            end else begin
               n.error_seen = 1'b1;
            end
         end
      end else if (b[7:6] != utv_pkg::CONT_TAG) begin
         // broken continuation drops the sequence
         n.error_seen    = 1'b1;
         n.pending_count = 2'd0;
      end else begin
         n.code_accum    = {s.code_accum[14:0], b[5:0]};
         n.pending_count = s.pending_count - 2'd1;
         if (n.pending_count == 2'd0) begin
            // completed code point: overlong, range and surrogate checks
            case (s.seq_class)
               utv_pkg::CLASS_THREE: floor_cp = utv_pkg::MIN_THREE;
               utv_pkg::CLASS_FOUR:  floor_cp = utv_pkg::MIN_FOUR;
               default:              floor_cp = utv_pkg::MIN_TWO;
            endcase
            if (n.code_accum < floor_cp || n.code_accum > utv_pkg::CODE_MAX ||
                (n.code_accum >= utv_pkg::SURROGATE_LO &&
                 n.code_accum <= utv_pkg::SURROGATE_HI))
               n.error_seen = 1'b1;
         end
      end
      return n;
   endfunction

   // compare verdicts, then take in the new byte
   always @(posedge clock) begin
      if (reset) begin
         decoder = '0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %b with no string finished",
                                         rsp_is_valid));
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_seen++;
               if (rsp_is_valid !== want)
                  report_mismatch($sformatf("verdict %0d: is_valid %b, wanted %b",
                                            verdicts_seen, rsp_is_valid, want));
               if (rsp_is_valid === 1'b1)
                  valid_seen++;
            end
         end
         if (req_valid && req_ready) begin
            decoder = decode_byte(decoder, req_byte_in);
            if (req_is_last) begin
               expected_verdicts.push_back(!decoder.error_seen &&
                                           decoder.pending_count == 2'd0);
               decoder = '0;
            end
         end
      end
      verdicts_owed = expected_verdicts.size();
   end

endmodule

// ===== tb/utf8_tag_validator_test.sv =====
`timescale 1ns / 1ps

module utf8_tag_validator_test;

   localparam int BYTE_TARGET = 1550;
   localparam int CYCLE_LIMIT = 200000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_byte_in = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_ready   = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_is_valid;

   logic       req_took = 1'b0;
   logic       calm     = 1'b0;
   int         mismatch_count;
   int         verdicts_owed;
   int         verdicts_seen;
   int         valid_seen;
   int         cycle_count  = 0;
   int         bytes_sent   = 0;
   int         strings_sent = 0;
   logic [7:0] text[$];

   utf8_tag_validator u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_byte_in  (req_byte_in),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_valid (rsp_is_valid)
   );

   utf8_verdict_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_valid   (rsp_is_valid),
      .mismatch_count (mismatch_count),
      .verdicts_owed  (verdicts_owed),
      .verdicts_seen  (verdicts_seen),
      .valid_seen     (valid_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // note item acceptance for the driver at the next falling edge
   always @(posedge clock) begin
      req_took <= req_valid && req_ready && !reset;
   end

   // random back-pressure on the verdict side
   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= 16);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("utf8_tag_validator_test NOT OK");
         $finish;
      end
   end

   // one byte, held until accepted; called at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      req_is_last <= last;
      do @(negedge clock); while (!req_took);
      bytes_sent++;
      if (last)
         strings_sent++;
   endtask

   // short string packed into a word, first byte highest
   task automatic send_word(input logic [31:0] w, input int n);
      for (int i = 0; i < n; i++)
         send_byte(w[8 * (n - 1 - i) +: 8], i == n - 1);
   endtask

   // encode a code point in n bytes, keeping only the first keep bytes
   task automatic put_code(input logic [20:0] cp, input int n, input int keep);
      logic [7:0] seq_bytes[4];
      case (n)
         1: seq_bytes[0] = {1'b0, cp[6:0]};
         2: begin
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {2'b10, cp[11:6]};
            seq_bytes[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {2'b10, cp[17:12]};
            seq_bytes[2] = {2'b10, cp[11:6]};
            seq_bytes[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++)
         text.push_back(seq_bytes[i]);
   endtask

   function automatic int natural_length(input logic [20:0] cp);
      if (cp < 21'h80)
         return 1;
      if (cp < 21'h800)
         return 2;
      if (cp < 21'h10000)
         return 3;
      return 4;
   endfunction

   // one character: mostly well formed, the rest broken in various ways
   task automatic add_char();
      int          pick;
      int          n;
      logic [20:0] cp;
      logic [7:0]  b;
      logic [20:0] edges[12];
      edges = '{21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff, 21'he000, 21'hffff,
                21'h10000, 21'h10ffff, 21'hd800, 21'hdfff, 21'h110000};
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         b = 8'($urandom_range(8'h20, 8'h7e));
         text.push_back(b);
      end else if (pick < 50) begin
         cp = 21'($urandom_range(21'h80, 21'h7ff));
         put_code(cp, 2, 2);
      end else if (pick < 65) begin
         cp = 21'($urandom_range(21'h800, 21'hffff));
         if (cp >= 21'hd800 && cp <= 21'hdfff)
            cp = cp ^ 21'h2000;
         put_code(cp, 3, 3);
      end else if (pick < 75) begin
         cp = 21'($urandom_range(21'h10000, 21'h10ffff));
         put_code(cp, 4, 4);
      end else if (pick < 80) begin
         // code points at the edges of the classes
         cp = edges[$urandom_range(0, 11)];
         n  = natural_length(cp);
         put_code(cp, n, n);
      end else if (pick < 88) begin
         // any byte at all, controls and stray continuations included
         b = 8'($urandom_range(0, 255));
         text.push_back(b);
      end else if (pick < 92) begin
         // overlong forms
         n  = $urandom_range(2, 4);
         cp = 21'((n == 2) ? $urandom_range(0, 21'h7f) :
                  (n == 3) ? $urandom_range(0, 21'h7ff) : $urandom_range(0, 21'hffff));
         put_code(cp, n, n);
      end else if (pick < 95) begin
         cp = 21'($urandom_range(21'hd800, 21'hdfff));
         put_code(cp, 3, 3);
      end else if (pick < 98) begin
         cp = 21'($urandom_range(21'h110000, 21'h1fffff));
         put_code(cp, 4, 4);
      end else begin
         // sequence cut short
         n  = $urandom_range(3, 4);
         cp = 21'((n == 3) ? $urandom_range(21'h800, 21'hd7ff) :
                             $urandom_range(21'h10000, 21'h10ffff));
         put_code(cp, n, $urandom_range(1, n - 1));
      end
   endtask

   initial begin
      int chars;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings: single bytes at the extremes, class limits,
      // surrogates, values past the top, newline as a continuation,
      // a cut-off sequence and a stray continuation as lead
      send_word(32'h00, 1);
      send_word(32'h0a, 1);
      send_word(32'h7f, 1);
      send_word(32'hff, 1);
      send_word(32'hc280, 2);
      send_word(32'he09fbf, 3);
      send_word(32'heda080, 3);
      send_word(32'hf48fbfbf, 4);
      send_word(32'hf4908080, 4);
      send_word(32'hc20a, 2);
      send_word(32'he282, 2);
      send_word(32'h8041, 2);

      // random strings, with a quiet stretch where neither side idles
      while (bytes_sent < BYTE_TARGET) begin
         calm = (bytes_sent >= 500 && bytes_sent < 800);
         text.delete();
         chars = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
         repeat (chars) add_char();
         foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (verdicts_owed != 0) @(negedge clock);
      repeat (6) @(negedge clock);

      $display("sent %0d strings in %0d bytes", strings_sent, bytes_sent);
      $display("compared %0d verdicts, %0d of them valid", verdicts_seen, valid_seen);
      if (mismatch_count == 0) begin
         $display("utf8_tag_validator_test OK");
      end else begin
         $display("utf8_tag_validator_test NOT OK");
      end
      $finish;
   end

endmodule
